// ===== src/emss_pkg.sv =====
// shared types, marker constants and match-length function for the exit marker scanner
package emss_pkg;

  localparam int MarkerLen = 22;
  localparam int LenW      = 5;

  // marker text as ascii codes, first character at index 0
  localparam logic [0:MarkerLen-1][7:0] MARKER = {
    8'h5F, 8'h5F, 8'h45, 8'h54, 8'h5F, 8'h50, 8'h41, 8'h53, 8'h53, 8'h45, 8'h4E,
    8'h47, 8'h45, 8'h52, 8'h5F, 8'h45, 8'h58, 8'h49, 8'h54, 8'h5F, 8'h5F, 8'h3A
  };

  localparam logic [7:0] NEWLINE_BYTE    = 8'h0A;
  localparam logic [7:0] ZERO_BYTE       = 8'h00;
  localparam logic [7:0] SPACE_BYTE      = 8'h20;
  localparam logic [7:0] TAB_BYTE        = 8'h09;
  localparam logic [7:0] VTAB_BYTE       = 8'h0B;
  localparam logic [7:0] FFEED_BYTE      = 8'h0C;
  localparam logic [7:0] CRET_BYTE       = 8'h0D;
  localparam logic [7:0] PLUS_BYTE       = 8'h2B;
  localparam logic [7:0] MINUS_BYTE      = 8'h2D;
  localparam logic [7:0] DIGIT0_BYTE     = 8'h30;
  localparam logic [7:0] DIGIT9_BYTE     = 8'h39;
  localparam logic [31:0] NO_DIGIT_STATUS = 32'd255;

  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_REARM = 1'b1;

  typedef enum logic [2:0] {
    PH_PASS   = 3'b001,
    PH_SCAN   = 3'b010,
    PH_STATUS = 3'b100
  } phase_t;

  typedef struct packed {
    logic ovf;
    logic stop;
    logic digit;
    logic neg;
    logic sign;
  } parse_flags_t;

  // row h, bit k: marker[h+1-k .. h-1] equals marker[0 .. k-2], with k <= h+1
  function automatic logic [MarkerLen-1:0][MarkerLen-1:0] build_border();
    logic [MarkerLen-1:0][MarkerLen-1:0] tbl;
    logic ok;
    tbl = '0;
    for (int h = 0; h < MarkerLen; h++) begin
      for (int k = 1; k < MarkerLen; k++) begin
        ok = (k <= h + 1);
        for (int j = 0; j < MarkerLen; j++) begin
          if (ok && (j <= k - 2) && (MARKER[h + 1 - k + j] != MARKER[j])) begin
            ok = 1'b0;
          end
        end
        tbl[h][k] = ok;
      end
    end
    return tbl;
  endfunction

  localparam logic [MarkerLen-1:0][MarkerLen-1:0] BORDER = build_border();

  // longest marker prefix that ends the held prefix of length h followed by c
  function automatic logic [LenW-1:0] next_len(logic [LenW-1:0] h, logic [7:0] c);
    logic [LenW-1:0] n;
    n = '0;
    for (int k = 1; k < MarkerLen; k++) begin
      if (BORDER[h][k] && (c == MARKER[k - 1])) begin
        n = LenW'(k);
      end
    end
    return n;
  endfunction

endpackage

// ===== src/exit_marker_stream_scanner_unit.sv =====
// exit marker stream scanner: marker match, byte release, status line parse
// result: the first result word of an accepted word is registered, visible the cycle after acceptance
// throughput: one word per cycle while the output is taken; a mismatch that releases
//   more than one byte keeps in_ready low while the release drains
// the output register frees as its word is taken, so passthrough runs back to back
// reset (rst_n low, synchronous): passthrough phase, no held bytes, parse cleared,
//   no output pending
module exit_marker_stream_scanner_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_status_valid,
  output logic [31:0] out_exit_status,
  output logic        out_last
);
  import emss_pkg::*;

  // scanner state
  phase_t          phase_r, phase_nxt;
  logic [LenW-1:0] match_len_r, match_len_nxt;
  logic [63:0]     acc_r, acc_nxt;
  parse_flags_t    flags_r, flags_nxt;

  // release drain: index of next held byte to send, count, prefix length, new byte
  logic            pend_act_r, pend_act_nxt;
  logic [LenW-1:0] pend_idx_r, pend_idx_nxt;
  logic [LenW-1:0] pend_end_r, pend_end_nxt;
  logic [LenW-1:0] pend_h_r, pend_h_nxt;
  logic [7:0]      pend_c_r, pend_c_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_bv_r, out_bv_nxt;
  logic        out_sv_r, out_sv_nxt;
  logic [31:0] out_st_r, out_st_nxt;
  logic        out_last_r, out_last_nxt;

  logic            out_free;
  logic            in_fire;
  logic            full_match;
  logic [LenW-1:0] scan_n;
  logic [LenW-1:0] rel_cnt;
  logic            is_digit;
  logic            is_blank;
  logic [3:0]      digit_val;
  logic [67:0]     acc_mac;
  logic [31:0]     status_val;
  logic            drain_last;
  logic [7:0]      drain_byte;

  // result produced directly by the accepted word
  logic        res_valid;
  logic [7:0]  res_byte;
  logic        res_bv;
  logic        res_sv;
  logic [31:0] res_st;
  logic        res_last;

  assign out_free = !out_valid_r || out_ready;
  // the drain owns the output register until the last released byte is loaded
  assign in_ready = out_free && !pend_act_r;
  assign in_fire  = in_valid && in_ready;

  // kmp step over the held prefix plus the new byte
  assign full_match = (match_len_r == LenW'(MarkerLen - 1))
                    && (in_data_byte == MARKER[MarkerLen - 1]);
  assign scan_n     = next_len(match_len_r, in_data_byte);
  // bytes released: held + 1 - kept
  assign rel_cnt    = match_len_r + LenW'(1) - scan_n;

  // status line character classes
  assign is_digit  = (in_data_byte >= DIGIT0_BYTE) && (in_data_byte <= DIGIT9_BYTE);
  assign is_blank  = (in_data_byte == SPACE_BYTE) || (in_data_byte == TAB_BYTE)
                  || (in_data_byte == VTAB_BYTE) || (in_data_byte == FFEED_BYTE)
                  || (in_data_byte == CRET_BYTE);
  assign digit_val = 4'(in_data_byte - DIGIT0_BYTE);
  // acc*10 + digit as shift-add; any carry above bit 63 means saturation
  assign acc_mac   = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {64'd0, digit_val};

  // strtoul-style result of the line so far
  always_comb begin
    if (!flags_r.digit) begin
      status_val = NO_DIGIT_STATUS;
    end else if (flags_r.ovf) begin
      status_val = '1;
    end else if (flags_r.neg) begin
      status_val = 32'd0 - acc_r[31:0];
    end else begin
      status_val = acc_r[31:0];
    end
  end

  // drained byte: held marker prefix, then the new byte when it fits nowhere
  assign drain_byte = (pend_idx_r == pend_h_r) ? pend_c_r : MARKER[pend_idx_r];
  assign drain_last = ((pend_idx_r + LenW'(1)) == pend_end_r);

  // per-word state update and direct result
  always_comb begin
    phase_nxt     = phase_r;
    match_len_nxt = match_len_r;
    acc_nxt       = acc_r;
    flags_nxt     = flags_r;
    pend_act_nxt  = pend_act_r;
    pend_idx_nxt  = pend_idx_r;
    pend_end_nxt  = pend_end_r;
    pend_h_nxt    = pend_h_r;
    pend_c_nxt    = pend_c_r;
    res_valid     = 1'b0;
    res_byte      = 8'd0;
    res_bv        = 1'b0;
    res_sv        = 1'b0;
    res_st        = 32'd0;
    res_last      = 1'b1;

    // advance the release drain
    if (pend_act_r && out_free) begin
      pend_idx_nxt = pend_idx_r + LenW'(1);
      if (drain_last) begin
        pend_act_nxt = 1'b0;
      end
    end

    if (in_fire) begin
      if (in_operation == OP_REARM) begin
        match_len_nxt = '0;
        phase_nxt     = PH_SCAN;
        acc_nxt       = '0;
        flags_nxt     = '0;
      end else begin
        unique case (phase_r)
          PH_SCAN: begin
            if (full_match) begin
              match_len_nxt = '0;
              phase_nxt     = PH_STATUS;
              acc_nxt       = '0;
              flags_nxt     = '0;
            end else begin
              match_len_nxt = scan_n;
              if (rel_cnt != '0) begin
                res_valid = 1'b1;
                res_bv    = 1'b1;
                res_byte  = (match_len_r == '0) ? in_data_byte : MARKER[0];
                res_last  = (rel_cnt == LenW'(1));
                if (rel_cnt != LenW'(1)) begin
                  pend_act_nxt = 1'b1;
                  pend_idx_nxt = LenW'(1);
                  pend_end_nxt = rel_cnt;
                  pend_h_nxt   = match_len_r;
                  pend_c_nxt   = in_data_byte;
                end
              end
            end
          end
          PH_STATUS: begin
            if (in_data_byte == NEWLINE_BYTE) begin
              res_valid     = 1'b1;
              res_sv        = 1'b1;
              res_st        = status_val;
              phase_nxt     = PH_PASS;
              match_len_nxt = '0;
              acc_nxt       = '0;
              flags_nxt     = '0;
            end else if (!flags_r.stop) begin
              if (in_data_byte == ZERO_BYTE) begin
                flags_nxt.stop = 1'b1;
              end else if (is_digit) begin
                if (!flags_r.ovf) begin
                  flags_nxt.digit = 1'b1;
                  if (acc_mac[67:64] != 4'd0) begin
                    flags_nxt.ovf = 1'b1;
                    acc_nxt       = '1;
                  end else begin
                    acc_nxt = acc_mac[63:0];
                  end
                end
              end else if (!flags_r.sign && !flags_r.digit && is_blank) begin
                // leading blank, skipped
              end else if (!flags_r.sign && !flags_r.digit
                           && ((in_data_byte == PLUS_BYTE)
                               || (in_data_byte == MINUS_BYTE))) begin
                flags_nxt.sign = 1'b1;
                if (in_data_byte == MINUS_BYTE) begin
                  flags_nxt.neg = 1'b1;
                end
              end else begin
                flags_nxt.stop = 1'b1;
              end
            end
          end
          default: begin
            // passthrough
            res_valid = 1'b1;
            res_bv    = 1'b1;
            res_byte  = in_data_byte;
          end
        endcase
      end
    end
  end

  // output register load: drain first, then the direct result
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_bv_nxt    = out_bv_r;
    out_sv_nxt    = out_sv_r;
    out_st_nxt    = out_st_r;
    out_last_nxt  = out_last_r;
    if (pend_act_r && out_free) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = drain_byte;
      out_bv_nxt    = 1'b1;
      out_sv_nxt    = 1'b0;
      out_st_nxt    = 32'd0;
      out_last_nxt  = drain_last;
    end else if (res_valid) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = res_byte;
      out_bv_nxt    = res_bv;
      out_sv_nxt    = res_sv;
      out_st_nxt    = res_st;
      out_last_nxt  = res_last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_PASS;
      match_len_r <= '0;
      acc_r       <= '0;
      flags_r     <= '0;
      pend_act_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      match_len_r <= match_len_nxt;
      acc_r       <= acc_nxt;
      flags_r     <= flags_nxt;
      pend_act_r  <= pend_act_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    pend_end_r <= pend_end_nxt;
    pend_h_r   <= pend_h_nxt;
    pend_c_r   <= pend_c_nxt;
    out_byte_r <= out_byte_nxt;
    out_bv_r   <= out_bv_nxt;
    out_sv_r   <= out_sv_nxt;
    out_st_r   <= out_st_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_byte_valid   = out_bv_r;
  assign out_status_valid = out_sv_r;
  assign out_exit_status  = out_st_r;
  assign out_last         = out_last_r;

endmodule
